// ===== src/ttv_pkg.sv =====
`timescale 1ns / 1ps

package ttv_pkg;

    localparam int POS_WIDTH = 24;
    localparam int UV_WIDTH  = 16;
    localparam int OUT_WIDTH = 16;

    // fraction bits of the tangent
    localparam int FRAC = OUT_WIDTH - 2;

    // edge and uv delta widths
    localparam int PW = POS_WIDTH + 1;
    localparam int UW = UV_WIDTH + 1;
    // tangent and determinant widths
    localparam int TW = PW + UW;
    localparam int DW = 2 * UW;
    // shared multiplier operand width
    localparam int MW = (PW > 31) ? PW : 31;
    // magnitude register width
    localparam int AW = (TW > 31) ? TW : 31;
    // block scaling brings the largest magnitude into [2^NORM_MSB, 2^(NORM_MSB+1))
    localparam int NORM_MSB = 29;
    // sum of squares, root and root remainder widths
    localparam int LW  = 64;
    localparam int RW  = 32;
    localparam int RMW = RW + 2;
    // divider numerator width
    localparam int NW  = NORM_MSB + 1 + FRAC + 1;

    localparam int STEP_W = 6;

    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(8);
    localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(3);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(RW - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(FRAC);

    // datapath operations
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_HOLD  = 4'd1;
    localparam logic [3:0] OP_LOAD2 = 4'd2;
    localparam logic [3:0] OP_MUL   = 4'd3;
    localparam logic [3:0] OP_ABS   = 4'd4;
    localparam logic [3:0] OP_NORM  = 4'd5;
    localparam logic [3:0] OP_SQ    = 4'd6;
    localparam logic [3:0] OP_RINIT = 4'd7;
    localparam logic [3:0] OP_ROOT  = 4'd8;
    localparam logic [3:0] OP_DINIT = 4'd9;
    localparam logic [3:0] OP_DIV   = 4'd10;
    localparam logic [3:0] OP_DEND  = 4'd11;
    localparam logic [3:0] OP_OUT   = 4'd12;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] pos_x;
        logic signed [POS_WIDTH-1:0] pos_y;
        logic signed [POS_WIDTH-1:0] pos_z;
        logic signed [UV_WIDTH-1:0]  tex_u;
        logic signed [UV_WIDTH-1:0]  tex_v;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] tangent_x;
        logic signed [OUT_WIDTH-1:0] tangent_y;
        logic signed [OUT_WIDTH-1:0] tangent_z;
        logic                        degenerate;
    } out_item_t;

    typedef struct packed {
        logic [3:0]        op;
        logic [STEP_W-1:0] step;
        logic [1:0]        comp;
    } cmd_t;

    typedef struct packed {
        logic deg;
        logic norm_done;
        logic out_busy;
    } stat_t;

endpackage

// ===== src/triangle_tangent_vector_core.sv =====
`timescale 1ns / 1ps

// per-triangle unit tangent from vertex positions (Q8.16) and uv (Q4.12), vertices
// arriving one per transfer in triangle order; every third vertex yields one Q1.14
// tangent with a degenerate flag. corners 0 and 1 are only held. the closing
// corner runs a sequencer over one shared multiplier (edge products and
// determinant), a one-bit-per-cycle block-scaling shifter (run until the largest
// component sits in the target range), squaring of the three magnitudes, a
// bit-by-bit square root and a restoring divider run three times, once per
// component; a degenerate triangle skips scaling, root and division. the next
// vertex is taken as soon as the sequencer is idle, even while a finished tangent
// waits in the output register.
module triangle_tangent_vector_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ttv_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output ttv_pkg::out_item_t out_item
);
    import ttv_pkg::*;

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    ttv_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ttv_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== src/ttv_datapath.sv =====
`timescale 1ns / 1ps

module ttv_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  ttv_pkg::cmd_t    cmd,
    input  ttv_pkg::in_item_t in_item,
    output ttv_pkg::stat_t   stat,
    output logic             out_valid,
    input  logic             out_ready,
    output ttv_pkg::out_item_t out_item
);
    import ttv_pkg::*;

    logic signed [POS_WIDTH-1:0] hpos_reg [6];
    logic signed [UV_WIDTH-1:0]  huv_reg [4];
    logic signed [POS_WIDTH-1:0] in_pos [3];
    logic signed [PW-1:0]        e1_reg [3];
    logic signed [PW-1:0]        e2_reg [3];
    logic signed [UW-1:0]        du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [TW-1:0]        t_reg [3];
    logic signed [DW-1:0]        det_reg;
    logic [AW-1:0]               a_reg [3];
    logic [2:0]                  neg_reg;
    logic                        deg_reg;
    logic signed [MW-1:0]        mul_a, mul_b;
    logic signed [2*MW-1:0]      prod_reg;
    logic [LW-1:0]               l_reg;
    logic [LW-1:0]               x_reg;
    logic [RMW-1:0]              rem_reg;
    logic [RW-1:0]               root_reg;
    logic [RMW+1:0]              rem_sh;
    logic [RMW+1:0]              root_test;
    logic [RW-1:0]               drem_reg;
    logic [FRAC:0]               dq_reg;
    logic [RW:0]                 div_sh;
    logic                        div_ge;
    logic [AW-1:0]               a_sel;
    logic [NW-1:0]               num;
    logic [OUT_WIDTH-1:0]        tan_reg [3];
    logic                        hi_any, b_msb_any;
    logic                        out_valid_reg;
    out_item_t                   out_item_reg;

    assign in_pos[0] = in_item.pos_x;
    assign in_pos[1] = in_item.pos_y;
    assign in_pos[2] = in_item.pos_z;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        a_sel = '0;
        case (cmd.comp)
            2'd0:    a_sel = a_reg[0];
            2'd1:    a_sel = a_reg[1];
            2'd2:    a_sel = a_reg[2];
            default: a_sel = '0;
        endcase
        if (cmd.op == OP_MUL)
        begin
            case (cmd.step)
                6'd0:    begin mul_a = MW'(dv2_reg); mul_b = MW'(e1_reg[0]); end
                6'd1:    begin mul_a = MW'(dv1_reg); mul_b = MW'(e2_reg[0]); end
                6'd2:    begin mul_a = MW'(dv2_reg); mul_b = MW'(e1_reg[1]); end
                6'd3:    begin mul_a = MW'(dv1_reg); mul_b = MW'(e2_reg[1]); end
                6'd4:    begin mul_a = MW'(dv2_reg); mul_b = MW'(e1_reg[2]); end
                6'd5:    begin mul_a = MW'(dv1_reg); mul_b = MW'(e2_reg[2]); end
                6'd6:    begin mul_a = MW'(du1_reg); mul_b = MW'(dv2_reg); end
                6'd7:    begin mul_a = MW'(du2_reg); mul_b = MW'(dv1_reg); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (cmd.op == OP_SQ)
        begin
            case (cmd.step)
                6'd0:    mul_a = MW'($signed({1'b0, a_reg[0][NORM_MSB:0]}));
                6'd1:    mul_a = MW'($signed({1'b0, a_reg[1][NORM_MSB:0]}));
                6'd2:    mul_a = MW'($signed({1'b0, a_reg[2][NORM_MSB:0]}));
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end
    end

    // block scaling status
    always_comb
    begin
        hi_any    = 1'b0;
        b_msb_any = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            hi_any    = hi_any | (|a_reg[i][AW-1:NORM_MSB+1]);
            b_msb_any = b_msb_any | a_reg[i][NORM_MSB];
        end
    end

    assign rem_sh    = {rem_reg, x_reg[LW-1:LW-2]};
    assign root_test = (RMW+2)'({root_reg, 2'b01});
    assign div_sh    = {drem_reg, dq_reg[FRAC]};
    assign div_ge    = div_sh >= {1'b0, root_reg};
    assign num       = (NW'(a_sel[NORM_MSB:0]) << FRAC) + NW'(root_reg >> 1);

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_HOLD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cmd.comp == 2'd0)
                        hpos_reg[i] <= in_pos[i];
                    else
                        hpos_reg[3+i] <= in_pos[i];
                end
                if (cmd.comp == 2'd0)
                begin
                    huv_reg[0] <= in_item.tex_u;
                    huv_reg[1] <= in_item.tex_v;
                end
                else
                begin
                    huv_reg[2] <= in_item.tex_u;
                    huv_reg[3] <= in_item.tex_v;
                end
            end
            OP_LOAD2:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= PW'(hpos_reg[3+i]) - PW'(hpos_reg[i]);
                    e2_reg[i] <= PW'(in_pos[i]) - PW'(hpos_reg[i]);
                end
                du1_reg <= UW'(huv_reg[2]) - UW'(huv_reg[0]);
                dv1_reg <= UW'(huv_reg[3]) - UW'(huv_reg[1]);
                du2_reg <= UW'(in_item.tex_u) - UW'(huv_reg[0]);
                dv2_reg <= UW'(in_item.tex_v) - UW'(huv_reg[1]);
            end
            OP_MUL:
            begin
                // accumulate the product taken one step earlier
                case (cmd.step)
                    6'd1:    t_reg[0] <= TW'(prod_reg);
                    6'd2:    t_reg[0] <= t_reg[0] - TW'(prod_reg);
                    6'd3:    t_reg[1] <= TW'(prod_reg);
                    6'd4:    t_reg[1] <= t_reg[1] - TW'(prod_reg);
                    6'd5:    t_reg[2] <= TW'(prod_reg);
                    6'd6:    t_reg[2] <= t_reg[2] - TW'(prod_reg);
                    6'd7:    det_reg  <= DW'(prod_reg);
                    6'd8:    det_reg  <= det_reg - DW'(prod_reg);
                    default: ;
                endcase
            end
            OP_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    a_reg[i]   <= t_reg[i][TW-1] ? AW'(-t_reg[i]) : AW'(t_reg[i]);
                    neg_reg[i] <= t_reg[i][TW-1] ^ det_reg[DW-1];
                end
                deg_reg <= (det_reg == '0) ||
                           ((t_reg[0] == '0) && (t_reg[1] == '0) && (t_reg[2] == '0));
            end
            OP_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (hi_any)
                        a_reg[i] <= a_reg[i] >> 1;
                    else if (!b_msb_any)
                        a_reg[i] <= a_reg[i] << 1;
                end
            end
            OP_SQ:
            begin
                case (cmd.step)
                    6'd1:    l_reg <= LW'($unsigned(prod_reg));
                    6'd2:    l_reg <= l_reg + LW'($unsigned(prod_reg));
                    6'd3:    l_reg <= l_reg + LW'($unsigned(prod_reg));
                    default: ;
                endcase
            end
            OP_RINIT:
            begin
                x_reg    <= l_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_ROOT:
            begin
                x_reg <= x_reg << 2;
                if (rem_sh >= root_test)
                begin
                    rem_reg  <= RMW'(rem_sh - root_test);
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= RMW'(rem_sh);
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
            end
            OP_DINIT:
            begin
                drem_reg <= RW'(num >> (FRAC + 1));
                dq_reg   <= num[FRAC:0];
            end
            OP_DIV:
            begin
                drem_reg <= div_ge ? RW'(div_sh - {1'b0, root_reg}) : RW'(div_sh);
                dq_reg   <= {dq_reg[FRAC-1:0], div_ge};
            end
            OP_DEND:
            begin
                case (cmd.comp)
                    2'd0: tan_reg[0] <= neg_reg[0] ? -OUT_WIDTH'(dq_reg) : OUT_WIDTH'(dq_reg);
                    2'd1: tan_reg[1] <= neg_reg[1] ? -OUT_WIDTH'(dq_reg) : OUT_WIDTH'(dq_reg);
                    2'd2: tan_reg[2] <= neg_reg[2] ? -OUT_WIDTH'(dq_reg) : OUT_WIDTH'(dq_reg);
                    default: ;
                endcase
            end
            OP_OUT:
            begin
                if (deg_reg)
                begin
                    out_item_reg.tangent_x  <= '0;
                    out_item_reg.tangent_y  <= '0;
                    out_item_reg.tangent_z  <= '0;
                    out_item_reg.degenerate <= 1'b1;
                end
                else
                begin
                    out_item_reg.tangent_x  <= tan_reg[0];
                    out_item_reg.tangent_y  <= tan_reg[1];
                    out_item_reg.tangent_z  <= tan_reg[2];
                    out_item_reg.degenerate <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign stat.deg       = deg_reg;
    assign stat.norm_done = !hi_any && b_msb_any;
    assign stat.out_busy  = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign out_item       = out_item_reg;

endmodule

// ===== src/ttv_controller.sv =====
`timescale 1ns / 1ps

module ttv_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ttv_pkg::stat_t stat,
    output ttv_pkg::cmd_t  cmd
);
    import ttv_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_ABS   = 4'd2;
    localparam logic [3:0] S_NORM  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_RINIT = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_DINIT = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DEND  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        comp_reg, comp_next;
    logic [1:0]        cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        comp_next  = comp_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        cmd.comp   = comp_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cnt_reg < 2'd2)
                    begin
                        cmd.op   = OP_HOLD;
                        cmd.comp = cnt_reg;
                        cnt_next = cnt_reg + 2'd1;
                    end
                    else
                    begin
                        cmd.op     = OP_LOAD2;
                        cnt_next   = 2'd0;
                        step_next  = '0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                if (step_reg == MUL_LAST)
                    state_next = S_ABS;
                else
                    step_next = step_reg + 1'b1;
            end
            S_ABS:
            begin
                cmd.op     = OP_ABS;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (stat.deg)
                    state_next = S_FIN;
                else if (stat.norm_done)
                begin
                    step_next  = '0;
                    state_next = S_SQ;
                end
                else
                    cmd.op = OP_NORM;
            end
            S_SQ:
            begin
                cmd.op = OP_SQ;
                if (step_reg == SQ_LAST)
                    state_next = S_RINIT;
                else
                    step_next = step_reg + 1'b1;
            end
            S_RINIT:
            begin
                cmd.op     = OP_RINIT;
                step_next  = '0;
                comp_next  = 2'd0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.op = OP_ROOT;
                if (step_reg == ROOT_LAST)
                    state_next = S_DINIT;
                else
                    step_next = step_reg + 1'b1;
            end
            S_DINIT:
            begin
                cmd.op     = OP_DINIT;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (step_reg == DIV_LAST)
                    state_next = S_DEND;
                else
                    step_next = step_reg + 1'b1;
            end
            S_DEND:
            begin
                cmd.op = OP_DEND;
                if (comp_reg == 2'd2)
                    state_next = S_FIN;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_DINIT;
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            comp_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            comp_reg  <= comp_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
